// File: hdl/fxc_pkg.sv
package fxc_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    MODE_INT_TO_FIX   = 2'd0,
    MODE_FLT_TO_FIX   = 2'd1,
    MODE_FIX_TO_INT   = 2'd2,
    MODE_FIX_TO_FLT   = 2'd3
  } mode_t;

  localparam logic [WORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] NEG_MAX = 32'h8000_0000;

endpackage

// File: hdl/float_fixed_converter_core.sv
// The input transfer is captured in the input register; the conversion sits in
// one combinational pass, and its result is captured in the result register,
// which raises out_valid unless out_stall holds the output.
// Throughput: one item per cycle while out_stall is low; the result register
// lets a new input transfer while a finished result still waits.
// Reset: synchronous, active-low rst_n clears both valid flags.
module float_fixed_converter_core
  import fxc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic        out_overflow
);

  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic [31:0] s1_op_r;
  logic        out_valid_r;
  logic [31:0] result_r, result_nxt;
  logic        overflow_r, overflow_nxt;
  logic        out_ready;
  logic        s1_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (out_ready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_mode_r <= in_mode;
      s1_op_r   <= in_operand;
    end
    if (out_ready && s1_valid_r) begin
      result_r   <= result_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_result   = result_r;
  assign out_overflow = overflow_r;

  // ---- int to fixed
  logic [63:0] i2f_prod;
  logic        i2f_ovf;
  logic [31:0] i2f_res;
  always_comb begin
    i2f_prod = {{32{s1_op_r[31]}}, s1_op_r} << FRACTION_BITS;
    i2f_ovf  = !((&i2f_prod[63:31]) || !(|i2f_prod[63:31]));
    if (!i2f_ovf) i2f_res = i2f_prod[31:0];
    else if (s1_op_r[31]) i2f_res = NEG_MAX;
    else i2f_res = POS_MAX;
  end

  // ---- float to fixed
  logic        f_neg;
  logic [7:0]  f_ex;
  logic [22:0] f_man;
  logic signed [9:0] f_sh;
  logic [4:0]  f_r;
  logic [24:0] f_half_sh;
  logic [32:0] f_mag;
  logic        f2x_ovf;
  logic [31:0] f2x_res;
  logic [31:0] f_negmag;
  always_comb begin
    f_neg  = s1_op_r[31];
    f_ex   = s1_op_r[30:23];
    f_man  = s1_op_r[22:0];
    f_sh   = $signed({2'b00, f_ex}) + 10'(FRACTION_BITS) - 10'sd150;
    f_r    = 5'(-f_sh);
    f_half_sh = {1'b1, f_man, 1'b0} >> f_r;
    f_mag  = '0;
    f2x_ovf = 1'b0;
    f2x_res = '0;
    f_negmag = '0;
    if (f_ex == 8'hFF) begin
      f2x_ovf = 1'b1;
      if (f_man != '0) f2x_res = '0;
      else f2x_res = f_neg ? NEG_MAX : POS_MAX;
    end else if (f_ex == 8'h00) begin
      f2x_res = '0;
    end else if (f_sh > 10'sd8) begin
      f2x_ovf = 1'b1;
      f2x_res = f_neg ? NEG_MAX : POS_MAX;
    end else if (f_sh < -10'sd25) begin
      f2x_res = '0;
    end else begin
      if (f_sh >= 10'sd0) f_mag = {9'd0, 1'b1, f_man} << f_sh[3:0];
      else f_mag = 33'((26'(f_half_sh) + 26'd1) >> 1);
      f_negmag = 32'(~f_mag[31:0] + 32'd1);
      if (f_neg) begin
        if (f_mag > 33'h0_8000_0000) begin
          f2x_ovf = 1'b1;
          f2x_res = NEG_MAX;
        end else f2x_res = f_negmag;
      end else begin
        if (f_mag > 33'h0_7FFF_FFFF) begin
          f2x_ovf = 1'b1;
          f2x_res = POS_MAX;
        end else f2x_res = f_mag[31:0];
      end
    end
  end

  // ---- fixed to int, truncating toward zero
  logic [32:0] x2i_biased;
  logic [31:0] x2i_res;
  always_comb begin
    x2i_biased = {s1_op_r[31], s1_op_r};
    if (s1_op_r[31]) x2i_biased = x2i_biased + 33'((64'd1 << FRACTION_BITS) - 64'd1);
    x2i_res = 32'($signed(x2i_biased) >>> FRACTION_BITS);
  end

  // ---- fixed to float, round to nearest even
  logic [31:0] x_mag;
  logic [4:0]  x_p;
  logic [31:0] x_norm;
  logic [24:0] x_mant;
  logic        x_up;
  logic [5:0]  x_pf;
  logic [7:0]  x_ex;
  logic [31:0] x2f_res;
  always_comb begin
    x_mag = s1_op_r[31] ? 32'(~s1_op_r + 32'd1) : s1_op_r;
    x_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_mag[i]) x_p = 5'(i);
    end
    x_norm = x_mag << (5'd31 - x_p);
    x_up   = x_norm[7] && ((|x_norm[6:0]) || x_norm[8]);
    x_mant = {1'b0, x_norm[31:8]} + 25'(x_up);
    x_pf   = {1'b0, x_p};
    if (x_mant[24]) begin
      x_pf   = x_pf + 6'd1;
      x_mant = x_mant >> 1;
    end
    x_ex = 8'(x_pf) + 8'd127 - 8'(FRACTION_BITS);
    if (x_mag == '0) x2f_res = '0;
    else x2f_res = {s1_op_r[31], x_ex, x_mant[22:0]};
  end

  always_comb begin
    case (mode_t'(s1_mode_r))
      MODE_INT_TO_FIX: begin
        result_nxt = i2f_res;
        overflow_nxt = i2f_ovf;
      end
      MODE_FLT_TO_FIX: begin
        result_nxt = f2x_res;
        overflow_nxt = f2x_ovf;
      end
      MODE_FIX_TO_INT: begin
        result_nxt = x2i_res;
        overflow_nxt = 1'b0;
      end
      default: begin
        result_nxt = x2f_res;
        overflow_nxt = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/fxc_checker.sv
module fxc_protocol_checker
  import fxc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result,
  input logic        out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result) && $stable(out_overflow))
    else $error("stalled result changed");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("transfer did not reach the output");

  a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_result == POS_MAX || out_result == NEG_MAX || out_result == 32'd0)
    else $error("overflow with unsaturated result");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind float_fixed_converter_core fxc_protocol_checker u_fxc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_result   (out_result),
  .out_overflow (out_overflow)
);

// File: bench/fxc_checker.sv
`timescale 1ns / 100ps
module fxc_checker
  import fxc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_operand,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_result,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending
);

  logic [32:0] conv_q[$];

  function automatic logic [31:0] clamp_word(longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return POS_MAX;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return NEG_MAX;
    end
    return v[31:0];
  endfunction

  // returns {overflow, result}
  function automatic logic [32:0] convert(mode_t m, logic [31:0] op);
    logic ovf;
    logic [31:0] res;
    longint v;
    longint unsigned mag, mant, rem, half;
    int sh, p, ex, r;
    logic neg;
    ovf = 1'b0;
    res = '0;
    v = longint'($signed(op));
    case (m)
      MODE_INT_TO_FIX: begin
        res = clamp_word(v * (64'sd1 <<< FRACTION_BITS), ovf);
      end
      MODE_FLT_TO_FIX: begin
        neg = op[31];
        ex = int'(op[30:23]);
        if (ex == 255) begin
          ovf = 1'b1;
          res = (op[22:0] != 0) ? 32'd0 : (neg ? NEG_MAX : POS_MAX);
        end else if (ex != 0) begin
          sh = ex - 150 + FRACTION_BITS;
          mag = {40'd0, 1'b1, op[22:0]};
          if (sh > 8) begin
            ovf = 1'b1;
            res = neg ? NEG_MAX : POS_MAX;
          end else if (sh >= 0 || -sh <= 25) begin
            if (sh >= 0) mag = mag << sh;
            else mag = (mag + (64'd1 << (-sh - 1))) >> (-sh);
            res = clamp_word(neg ? -longint'(mag) : longint'(mag), ovf);
          end
        end
      end
      MODE_FIX_TO_INT: begin
        v = v / (64'sd1 <<< FRACTION_BITS);
        res = v[31:0];
      end
      default: begin
        mag = (v < 0) ? longint'(-v) : longint'(v);
        if (mag != 0) begin
          p = 0;
          while (p < 40 && (mag >> (p + 1)) != 0) p++;
          if (p <= 23) begin
            mant = mag << (23 - p);
          end else begin
            r = p - 23;
            rem = mag & ((64'd1 << r) - 1);
            half = 64'd1 << (r - 1);
            mant = mag >> r;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 24)) begin
              mant = mant >> 1;
              p++;
            end
          end
          ex = p + 127 - FRACTION_BITS;
          res = {op[31], ex[7:0], mant[22:0]};
        end
      end
    endcase
    return {ovf, res};
  endfunction

  always @(posedge clk) begin
    logic [32:0] exp_word;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        conv_q.push_back(convert(mode_t'(in_mode), in_operand));
      if (out_valid && !out_stall) begin
        if (conv_q.size() == 0) begin
          $error("result transfer with nothing expected: result %h", out_result);
          errs++;
        end else begin
          exp_word = conv_q.pop_front();
          if (out_result !== exp_word[31:0]) begin
            $error("result: expected %h actual %h", exp_word[31:0], out_result);
            errs++;
          end
          if (out_overflow !== exp_word[32]) begin
            $error("overflow: expected %b actual %b", exp_word[32], out_overflow);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= conv_q.size();
  end

endmodule

// File: bench/tb_float_fixed_converter_core.sv
`timescale 1ns / 100ps
module tb_float_fixed_converter_core
  import fxc_pkg::*;
();

  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [31:0] in_operand = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_result;
  logic out_overflow;
  int fail_count;
  int pending;
  int cycles = 0;
  bit calm = 1'b0;
  int rx_gap = 0;
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  float_fixed_converter_core dut (.*);

  fxc_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      rx_gap <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(mode_t m, logic [31:0] op);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_operand <= op;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [31:0] pick_operand(mode_t m);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w = $signed(w) >>> $urandom_range(0, 31);
      1: if (m == MODE_FLT_TO_FIX) w[30:23] = 8'($urandom_range(100, 165));
      2: if (m == MODE_FLT_TO_FIX) w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] dir_ops[12];
    mode_t m;
    dir_ops = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                32'h007F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
                32'h3F00_0000, 32'hBEFF_FFFF, 32'h4F00_0000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_ops[i])
      send(mode_t'(i % 4), dir_ops[i]);
    send(MODE_FLT_TO_FIX, 32'h3B80_0000);
    send(MODE_FLT_TO_FIX, 32'h3B40_0000);
    send(MODE_FIX_TO_FLT, 32'h0100_0001);
    send(MODE_FIX_TO_FLT, 32'h0100_0003);
    send(MODE_FIX_TO_INT, 32'hFFFF_FF01);
    send(MODE_INT_TO_FIX, 32'hFF80_0000);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // hold off until the pipe drains
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (i == RANDOM_ITEMS - 200) calm = 1'b1;
      m = mode_t'($urandom_range(0, 3));
      send(m, pick_operand(m));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d conversions over all four modes, with saturation, NaN, inf,", sent);
    $display("subnormal and rounding-tie operands, and random stalls on both sides.");
    if (fail_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
